@@ hw/rtl/vnorm_pkg.sv @@
// Package for the 3D vector normalizer: widths, stage counts and the lane count.
// No dependencies.
package vnorm_pkg;
	localparam int CompW  = 16;
	localparam int SumW   = 32;
	localparam int RootW  = 16;
	localparam int QuotW  = 15;          // quotient bits before clamp
	localparam int DivNumW = 30;         // |c| * 16384 fits in 30 bits
	localparam int RootSteps = RootW;    // one root bit per stage
	localparam int DivSteps  = QuotW;    // one quotient bit per stage
	localparam logic [CompW-1:0] UnitOne = 16'd16384;
	localparam int Lanes = 3;
endpackage

@@ hw/rtl/vnorm_root.sv @@
// Pipelined floor square root of the 32-bit sum of squares, one result bit per stage.
// Also forms the sum of squares up front. Uses vnorm_pkg.
module vnorm_root (
	input  logic clk,
	input  logic en,
	input  logic signed [vnorm_pkg::CompW-1:0] vec_x,
	input  logic signed [vnorm_pkg::CompW-1:0] vec_y,
	input  logic signed [vnorm_pkg::CompW-1:0] vec_z,
	output logic [vnorm_pkg::RootW-1:0] root
);
	localparam int N = vnorm_pkg::RootSteps;
	logic [vnorm_pkg::SumW-1:0] sq_x_s1, sq_y_s1, sq_z_s1;
	logic [vnorm_pkg::SumW+1:0] rem_q [N+1];
	logic [vnorm_pkg::RootW-1:0] rt_q [N+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s1 <= vnorm_pkg::SumW'(unsigned'(32'(vec_x * vec_x)));
			sq_y_s1 <= vnorm_pkg::SumW'(unsigned'(32'(vec_y * vec_y)));
			sq_z_s1 <= vnorm_pkg::SumW'(unsigned'(32'(vec_z * vec_z)));
			rem_q[0] <= 34'(sq_x_s1) + 34'(sq_y_s1) + 34'(sq_z_s1);
			rt_q[0]  <= '0;
		end
	end

	// restoring root: stage i decides bit N-1-i
	for (genvar i = 0; i < N; i++) begin : g_step
		localparam int B = N - 1 - i;
		logic [vnorm_pkg::SumW+1:0] trial;
		assign trial = ((34'(rt_q[i]) << (B + 1)) | (34'd1 << (2 * B)));
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_q[i] >= trial) begin
					rem_q[i+1] <= rem_q[i] - trial;
					rt_q[i+1]  <= rt_q[i] | (vnorm_pkg::RootW'(1) << B);
				end else begin
					rem_q[i+1] <= rem_q[i];
					rt_q[i+1]  <= rt_q[i];
				end
			end
		end
	end
	assign root = rt_q[N];
	// pipeline depth: 2 + N
endmodule

@@ hw/rtl/vnorm_lane.sv @@
// One divide lane: |c| * 16384 / len, restoring, one quotient bit per stage, clamp and sign.
// Uses vnorm_pkg.
module vnorm_lane (
	input  logic clk,
	input  logic en,
	input  logic signed [vnorm_pkg::CompW-1:0] comp,
	input  logic [vnorm_pkg::RootW-1:0] divisor,
	output logic [vnorm_pkg::CompW-1:0] unit
);
	localparam int N = vnorm_pkg::DivSteps;
	localparam int W = vnorm_pkg::QuotW;
	logic [W-1:0] num_q [N+1];
	logic [vnorm_pkg::RootW-1:0] rem_q [N+1];
	logic [vnorm_pkg::RootW-1:0] dv_q [N+1];
	logic [W-1:0] qb_q [N+1];
	logic neg_q [N+1];
	logic [vnorm_pkg::CompW-1:0] mag;
	logic [vnorm_pkg::DivNumW-1:0] num;
	logic [vnorm_pkg::CompW-1:0] q;

	assign mag = comp[vnorm_pkg::CompW-1] ? vnorm_pkg::CompW'(-comp) : comp;
	assign num = {mag, 14'd0};

	// mag <= len, so the top W numerator bits are already below the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			num_q[0] <= num[W-1:0];
			rem_q[0] <= vnorm_pkg::RootW'(num[vnorm_pkg::DivNumW-1:W]);
			dv_q[0]  <= (divisor == '0) ? vnorm_pkg::RootW'(1) : divisor;
			qb_q[0]  <= '0;
			neg_q[0] <= comp[vnorm_pkg::CompW-1];
		end
	end

	// stage i shifts in one numerator bit and decides one quotient bit
	for (genvar i = 0; i < N; i++) begin : g_step
		logic [vnorm_pkg::RootW:0] r2;
		assign r2 = {rem_q[i], num_q[i][W-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				dv_q[i+1]  <= dv_q[i];
				neg_q[i+1] <= neg_q[i];
				num_q[i+1] <= {num_q[i][W-2:0], 1'b0};
				if (r2 >= {1'b0, dv_q[i]}) begin
					rem_q[i+1] <= vnorm_pkg::RootW'(r2 - {1'b0, dv_q[i]});
					qb_q[i+1]  <= {qb_q[i][W-2:0], 1'b1};
				end else begin
					rem_q[i+1] <= vnorm_pkg::RootW'(r2);
					qb_q[i+1]  <= {qb_q[i][W-2:0], 1'b0};
				end
			end
		end
	end

	assign q = (vnorm_pkg::CompW'(qb_q[N]) > vnorm_pkg::UnitOne) ? vnorm_pkg::UnitOne
		: vnorm_pkg::CompW'(qb_q[N]);
	assign unit = neg_q[N] ? vnorm_pkg::CompW'(-q) : q;
endmodule

@@ hw/rtl/vector3_normalize.sv @@
// Top level of the 3D vector normalizer: root pipeline, three divide lanes, output merge.
// Uses vnorm_pkg, vnorm_root, vnorm_lane.
// Result path: square and sum registers, root stages, divide lane input register and divide stages.
// Throughput: one vector per cycle; the whole pipe advances when the output is free.
// Reset (arst_n low) clears only the valid bits; data registers are not reset.
module vector3_normalize (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [47:0] s_tdata,   // vec_x[15:0], vec_y[31:16], vec_z[47:32]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [63:0] m_tdata    // unit_x, unit_y, unit_z, magnitude (16 bits each)
);
	localparam int RootLat = 2 + vnorm_pkg::RootSteps;
	localparam int Lat = RootLat + vnorm_pkg::DivSteps + 1;
	logic [Lat-1:0] vld_q;
	logic en;
	logic [vnorm_pkg::RootW-1:0] root;
	logic [vnorm_pkg::CompW-1:0] cmp_q [vnorm_pkg::Lanes][RootLat];
	logic [vnorm_pkg::RootW-1:0] mag_q [vnorm_pkg::DivSteps+1];
	logic [vnorm_pkg::CompW-1:0] unit [vnorm_pkg::Lanes];

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[Lat-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Lat-2:0], s_tvalid};
	end

	vnorm_root u_root (.clk, .en,
		.vec_x(s_tdata[15:0]), .vec_y(s_tdata[31:16]), .vec_z(s_tdata[47:32]), .root);

	for (genvar l = 0; l < vnorm_pkg::Lanes; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en) begin
				cmp_q[l][0] <= s_tdata[16*l +: 16];
				for (int k = 1; k < RootLat; k++) cmp_q[l][k] <= cmp_q[l][k-1];
			end
		end
		vnorm_lane u_lane (.clk, .en, .comp(cmp_q[l][RootLat-1]), .divisor(root),
			.unit(unit[l]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q[0] <= root;
			for (int k = 1; k <= vnorm_pkg::DivSteps; k++) mag_q[k] <= mag_q[k-1];
		end
	end

	// merge: lanes are already aligned to the magnitude delay line
	assign m_tdata = {mag_q[vnorm_pkg::DivSteps], unit[2], unit[1], unit[0]};

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready)) else $error("ready");
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384))
		else $error("range");
endmodule

@@ sim/tb_top.sv @@
// Testbench for vector3_normalize: stream driver, monitor and a behavioral normalizer predictor.
// Depends on vnorm_pkg and the vector3_normalize RTL.
module tb_top;
	typedef struct packed {
		logic [15:0] mag;
		logic [15:0] uz;
		logic [15:0] uy;
		logic [15:0] ux;
	} unit_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;   // vec_x[15:0], vec_y[31:16], vec_z[47:32]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;        // unit_x, unit_y, unit_z, magnitude

	logic [47:0] vec_queue[$];
	unit_res_t expected_units[$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	int cycles = 0;
	bit stim_done = 0;
	bit hold_rx = 0;
	bit hold_done = 0;
	int hold_cnt = 0;
	bit drain_wait = 0;
	bit drain_done = 0;
	int tx_gap = 0;
	int rx_gap = 0;

	vector3_normalize dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] isqrt(input logic [31:0] n);
		logic [31:0] r;
		r = 0;
		for (int b = 15; b >= 0; b--) begin
			if ((64'(r | (32'd1 << b)) * 64'(r | (32'd1 << b))) <= 64'(n))
				r = r | (32'd1 << b);
		end
		return r;
	endfunction

	function automatic logic [15:0] unit_of(input logic signed [15:0] c, input logic [31:0] d);
		logic [31:0] m;
		logic [31:0] q;
		m = c < 0 ? 32'(-32'sd1 * c) : 32'(c);
		q = (m * 32'(vnorm_pkg::UnitOne)) / d;
		if (q > 32'(vnorm_pkg::UnitOne))
			q = 32'(vnorm_pkg::UnitOne);
		return c < 0 ? 16'(-q) : q[15:0];
	endfunction

	function automatic unit_res_t normalize(input logic [47:0] v);
		logic signed [15:0] x, y, z;
		logic [31:0] sum, len, d;
		unit_res_t r;
		x = v[15:0];
		y = v[31:16];
		z = v[47:32];
		sum = 32'(x * x) + 32'(y * y) + 32'(z * z);
		len = isqrt(sum);
		d = len < 1 ? 1 : len;
		r.ux = unit_of(x, d);
		r.uy = unit_of(y, d);
		r.uz = unit_of(z, d);
		r.mag = len[15:0];
		return r;
	endfunction

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		errors++;
		$display("mismatch %s at result %0d: got %h want %h", what, received, got, want);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_units.push_back(normalize(s_tdata));
				sent++;
			end
			if (s_tvalid && !s_tready) begin
			end else if (drain_wait && expected_units.size() == 0) begin
				drain_wait <= 0;
			end else if (!drain_wait && tx_gap > 0) begin
				s_tvalid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (!drain_wait && vec_queue.size() > 0) begin
				if (!drain_done && sent >= 600) begin
					// pause until everything in flight has come out
					drain_wait <= 1;
					drain_done <= 1;
					s_tvalid <= 1'b0;
				end else begin
					s_tdata <= vec_queue.pop_front();
					s_tvalid <= 1'b1;
					tx_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		unit_res_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				received++;
				if (expected_units.size() == 0) begin
					errors++;
					$display("result %0d arrived with nothing expected", received);
				end else begin
					want = expected_units.pop_front();
					if (got.ux !== want.ux) report("unit_x", got.ux, want.ux);
					if (got.uy !== want.uy) report("unit_y", got.uy, want.uy);
					if (got.uz !== want.uz) report("unit_z", got.uz, want.uz);
					if (got.mag !== want.mag) report("magnitude", got.mag, want.mag);
				end
			end
			if (hold_rx) begin
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				m_tready <= 1'b0;
				rx_gap <= rx_gap - 1;
			end else begin
				m_tready <= 1'b1;
				rx_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
			end
		end
	end

	// long receiver hold-off so the pipe fills and back-pressures the input
	always @(posedge clk) begin
		if (hold_rx) begin
			if (hold_cnt == 0)
				hold_rx <= 0;
			else
				hold_cnt <= hold_cnt - 1;
		end else if (!hold_done && sent >= 200) begin
			hold_rx <= 1;
			hold_done <= 1;
			hold_cnt <= 300;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'(int'($urandom_range(0, 8)) - 4);
			3: return 16'(int'($urandom_range(0, 512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] ext[6];
		ext = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0100};
		// directed: zero vector, axes, tiny, extremes
		vec_queue.push_back({16'h0000, 16'h0000, 16'h0000});
		for (int i = 0; i < 6; i++)
			vec_queue.push_back({ext[(i + 2) % 6], ext[(i + 1) % 6], ext[i]});
		for (int i = 0; i < 6; i++) begin
			vec_queue.push_back({16'h0000, 16'h0000, ext[i]});
			vec_queue.push_back({16'h0000, ext[i], 16'h0000});
			vec_queue.push_back({ext[i], 16'h0000, 16'h0000});
		end
		vec_queue.push_back({16'h8000, 16'h8000, 16'h8000});
		vec_queue.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF});
		repeat (1280)
			vec_queue.push_back({rand_comp(), rand_comp(), rand_comp()});
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (vec_queue.size() == 0 && !s_tvalid);
		wait (expected_units.size() == 0);
		repeat (60) @(posedge clk);
		$display("%0d vectors sent, %0d results checked, incl. zero, axis and extreme vectors",
			sent, received);
		$display("with random stalls, a long output hold-off and a full drain pause");
		if (errors == 0 && expected_units.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
